>>> design/ddft_pkg.sv
// ----------------------------------------------------------------------------
// ddft_pkg
// Widths, register indexes and reset constants of the dual DAC feedback trim.
// ----------------------------------------------------------------------------
package ddft_pkg;

  localparam int REQ_W     = 16;
  localparam int TRIM_W    = 10;
  localparam int FB_W      = 12;
  localparam int FB_EN_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int SUM_W     = REQ_W + 2;
  localparam int CMP_W     = REQ_W + 1;
  localparam int NUM_CH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REQUEST_A   = 3'd0,
    REG_REQUEST_B   = 3'd1,
    REG_TRIM_MIN_A  = 3'd2,
    REG_TRIM_MAX_A  = 3'd3,
    REG_TRIM_MIN_B  = 3'd4,
    REG_TRIM_MAX_B  = 3'd5,
    REG_FEEDBACK_EN = 3'd6
  } cfg_reg_e;

  localparam logic signed [TRIM_W-1:0] TRIM_MIN_RST   = -10'sd50;
  localparam logic signed [TRIM_W-1:0] TRIM_MAX_RST   = 10'sd50;
  localparam logic        [REQ_W-1:0]  LAST_REQ_RST   = 16'hFFFF;
  localparam logic        [FB_EN_W-1:0] FEEDBACK_EN_RST = 2'b11;

endpackage

>>> design/ddft_if.sv
// ----------------------------------------------------------------------------
// ddft_if
// Valid/ready channels of the dual DAC feedback trim: tick input, code output
// and register write.
// ----------------------------------------------------------------------------
interface ddft_in_if;
  import ddft_pkg::*;

  logic            valid;
  logic            ready;
  logic            measure_mode;
  logic            update_enable;
  logic [FB_W-1:0] feedback_a;
  logic [FB_W-1:0] feedback_b;

  modport source (
    output valid, measure_mode, update_enable, feedback_a, feedback_b,
    input  ready
  );
  modport sink (
    input  valid, measure_mode, update_enable, feedback_a, feedback_b,
    output ready
  );
endinterface

interface ddft_out_if #(
  parameter int DAC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [DAC_BITS-1:0] dac_code_a;
  logic [DAC_BITS-1:0] dac_code_b;

  modport source (
    output valid, dac_code_a, dac_code_b,
    input  ready
  );
  modport sink (
    input  valid, dac_code_a, dac_code_b,
    output ready
  );
endinterface

interface ddft_cfg_if;
  import ddft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> design/dual_dac_feedback_trim.sv
// ----------------------------------------------------------------------------
// dual_dac_feedback_trim
// A tick transfer gives its codes through the input register, then the
// result register. Throughput: one tick per cycle, limited only by the
// result register draining. Reset: last requests all ones, codes and trims
// zero, trim bounds -50/50, feedback enabled on both channels.
// ----------------------------------------------------------------------------
module dual_dac_feedback_trim #(
  parameter int DAC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ddft_in_if.sink                          in_i,
  ddft_out_if.source                       out_o,
  ddft_cfg_if.sink                         cfg_i
);
  import ddft_pkg::*;

  localparam logic [SUM_W-1:0] CODE_MAX = SUM_W'((1 << DAC_BITS) - 1);

  // configuration registers
  logic        [REQ_W-1:0]   req_q  [NUM_CH];
  logic signed [TRIM_W-1:0]  tmin_q [NUM_CH];
  logic signed [TRIM_W-1:0]  tmax_q [NUM_CH];
  logic        [FB_EN_W-1:0] fb_en_q;

  // input register
  logic            s1_valid_q;
  logic            s1_measure_q;
  logic            s1_update_q;
  logic [FB_W-1:0] s1_fb_q [NUM_CH];

  // channel state
  logic        [REQ_W-1:0]    last_req_q [NUM_CH];
  logic        [REQ_W-1:0]    last_req_d [NUM_CH];
  logic        [DAC_BITS-1:0] code_q     [NUM_CH];
  logic        [DAC_BITS-1:0] code_d     [NUM_CH];
  logic signed [TRIM_W-1:0]   trim_q     [NUM_CH];
  logic signed [TRIM_W-1:0]   trim_d     [NUM_CH];
  logic        [FB_EN_W-1:0]  last_fb_en_q;
  logic                       last_fb_en_d [NUM_CH];

  // result register
  logic                out_valid_q;
  logic [DAC_BITS-1:0] out_code_q [NUM_CH];

  logic out_free;
  logic s1_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_update_q || out_free);
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        req_q[c]  <= '0;
        tmin_q[c] <= TRIM_MIN_RST;
        tmax_q[c] <= TRIM_MAX_RST;
      end
      fb_en_q <= FEEDBACK_EN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_REQUEST_A:   req_q[0]  <= cfg_i.data[REQ_W-1:0];
        REG_REQUEST_B:   req_q[1]  <= cfg_i.data[REQ_W-1:0];
        REG_TRIM_MIN_A:  tmin_q[0] <= $signed(cfg_i.data[TRIM_W-1:0]);
        REG_TRIM_MAX_A:  tmax_q[0] <= $signed(cfg_i.data[TRIM_W-1:0]);
        REG_TRIM_MIN_B:  tmin_q[1] <= $signed(cfg_i.data[TRIM_W-1:0]);
        REG_TRIM_MAX_B:  tmax_q[1] <= $signed(cfg_i.data[TRIM_W-1:0]);
        REG_FEEDBACK_EN: fb_en_q   <= cfg_i.data[FB_EN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_measure_q <= in_i.measure_mode;
      s1_update_q  <= in_i.update_enable;
      s1_fb_q[0]   <= in_i.feedback_a;
      s1_fb_q[1]   <= in_i.feedback_b;
    end
  end

  // per-channel trim logic
  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    logic                     req_changed;
    logic                     toggled;
    logic                     above;
    logic                     below;
    logic signed [TRIM_W-1:0] trim_base;
    logic signed [TRIM_W-1:0] trim_step;
    logic signed [SUM_W-1:0]  sum_req;
    logic signed [SUM_W-1:0]  sum_trim;
    logic signed [SUM_W-1:0]  sum_step;
    logic [CMP_W-1:0]         fb_ext;
    logic [CMP_W-1:0]         req_ext;

    function automatic logic [DAC_BITS-1:0] sat_code(input logic signed [SUM_W-1:0] s);
      logic [DAC_BITS-1:0] r;
      if (s < 0) begin
        r = '0;
      end else if (s > $signed(CODE_MAX)) begin
        r = CODE_MAX[DAC_BITS-1:0];
      end else begin
        r = s[DAC_BITS-1:0];
      end
      return r;
    endfunction

    assign req_changed = last_req_q[g] != req_q[g];
    assign toggled     = last_fb_en_q[g] != fb_en_q[g];
    assign fb_ext      = CMP_W'(s1_fb_q[g]);
    assign req_ext     = CMP_W'(req_q[g]);
    assign above       = fb_ext > req_ext + CMP_W'(1);
    assign below       = fb_ext + CMP_W'(1) < req_ext;
    assign trim_base   = toggled ? '0 : trim_q[g];
    assign sum_req     = $signed({2'b00, req_q[g]});
    assign sum_trim    = sum_req + SUM_W'(trim_q[g]);
    assign sum_step    = sum_req + SUM_W'(trim_step);

    always_comb begin
      trim_step = trim_base;
      if (fb_en_q[g]) begin
        if (above) begin
          if (trim_base > tmin_q[g]) trim_step = trim_base - TRIM_W'(1);
        end else if (below) begin
          if (trim_base < tmax_q[g]) trim_step = trim_base + TRIM_W'(1);
        end
      end
    end

    always_comb begin
      last_req_d[g]   = last_req_q[g];
      code_d[g]       = code_q[g];
      trim_d[g]       = trim_q[g];
      last_fb_en_d[g] = last_fb_en_q[g];
      if (!s1_measure_q) begin
        if (req_changed) code_d[g] = sat_code(sum_trim);
      end else if (req_changed) begin
        last_req_d[g] = req_q[g];
        code_d[g]     = sat_code(sum_req);
        trim_d[g]     = '0;
      end else begin
        last_fb_en_d[g] = fb_en_q[g];
        trim_d[g]       = trim_step;
        code_d[g]       = sat_code(sum_step);
      end
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        last_req_q[c] <= LAST_REQ_RST;
        code_q[c]     <= '0;
        trim_q[c]     <= '0;
      end
      last_fb_en_q <= '0;
    end else if (s1_fire) begin
      for (int c = 0; c < NUM_CH; c++) begin
        last_req_q[c]   <= last_req_d[c];
        code_q[c]       <= code_d[c];
        trim_q[c]       <= trim_d[c];
        last_fb_en_q[c] <= last_fb_en_d[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_update_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_update_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_code_q[c] <= code_d[c];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.dac_code_a = out_code_q[0];
  assign out_o.dac_code_b = out_code_q[1];

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_update_q |=> out_valid_q)
    else $error("tick with update gave no result");

  a_tick_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid_q)
    else $error("accepted tick lost before input register");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_update_q)
      && $stable(s1_measure_q))
    else $error("stalled tick changed in input register");

  a_last_req_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && s1_measure_q) |=> $stable(last_req_q[0]) && $stable(last_req_q[1]))
    else $error("last request moved outside a measure tick");
`endif

endmodule
